// ===== design/bir_pkg.sv =====
// Shared types and constants for the box integrate and reflect block.
package bir_pkg;

  typedef logic signed [31:0] q16_t;

  typedef struct packed {
    q16_t        pos;
    q16_t        vel;
    logic [30:0] size;
  } axis_in_t;

  typedef enum logic [2:0] {
    CFG_BOUND_LEFT  = 3'd0,
    CFG_BOUND_RIGHT = 3'd1,
    CFG_BOUND_DOWN  = 3'd2,
    CFG_BOUND_UP    = 3'd3,
    CFG_BOUND_BACK  = 3'd4,
    CFG_BOUND_FRONT = 3'd5,
    CFG_SPEED_SCALE = 3'd6
  } cfg_idx_t;

  localparam int unsigned NUM_STAGES = 6;
  localparam int unsigned STEP_W     = 33;
  localparam logic [STEP_W-1:0] STEP_MAX = 33'h1_0000_0000;

  localparam q16_t        BOUND_LO_RST = 32'shFF9C_0000;
  localparam q16_t        BOUND_HI_RST = 32'sh0064_0000;
  localparam logic [24:0] SCALE_RST    = 25'h001_0000;

endpackage

// ===== design/box_integrate_and_reflect.sv =====
// Top level: config registers, item delay line, step unit and three axis pipes.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_stall   | in_pos_*, in_vel_*, in_size_*, in_time_step
//  out     | out_valid / out_stall | out_new_pos_*, out_new_vel_*
//  cfg     | cfg_we                | cfg_addr, cfg_wdata
//
// Six-stage pipeline, one item per cycle while no result is held under out_stall. The stages are the
// step multiply, step cap, vel*step multiply, saturated add, face sums, and the
// bound compare into the output register. Synchronous reset clears the valid
// bits and loads the default bounds and speed scale. The whole pipe holds while
// a result waits under out_stall and advances in every other cycle.
module box_integrate_and_reflect (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bir_pkg::q16_t        in_pos_x,
  input  bir_pkg::q16_t        in_pos_y,
  input  bir_pkg::q16_t        in_pos_z,
  input  bir_pkg::q16_t        in_vel_x,
  input  bir_pkg::q16_t        in_vel_y,
  input  bir_pkg::q16_t        in_vel_z,
  input  logic [30:0]          in_size_x,
  input  logic [30:0]          in_size_y,
  input  logic [30:0]          in_size_z,
  input  logic [24:0]          in_time_step,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bir_pkg::q16_t        out_new_pos_x,
  output bir_pkg::q16_t        out_new_pos_y,
  output bir_pkg::q16_t        out_new_pos_z,
  output bir_pkg::q16_t        out_new_vel_x,
  output bir_pkg::q16_t        out_new_vel_y,
  output bir_pkg::q16_t        out_new_vel_z,
  input  logic                 cfg_we,
  input  bir_pkg::cfg_idx_t    cfg_addr,
  input  logic [31:0]          cfg_wdata
);
  import bir_pkg::*;

  q16_t        bound_r [6];
  logic [24:0] scale_r;

  logic [NUM_STAGES-1:0] vld_r;
  logic                  en;

  axis_in_t    din   [3];
  axis_in_t    d1_r  [3];
  axis_in_t    d2_r  [3];
  logic [STEP_W-1:0] step;
  q16_t        npos  [3];
  q16_t        nvel  [3];

  assign en       = !(vld_r[NUM_STAGES-1] && out_stall);
  assign in_stall = !en;

  always_comb begin
    din[0] = '{pos: in_pos_x, vel: in_vel_x, size: in_size_x};
    din[1] = '{pos: in_pos_y, vel: in_vel_y, size: in_size_y};
    din[2] = '{pos: in_pos_z, vel: in_vel_z, size: in_size_z};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_r[0] <= BOUND_LO_RST;
      bound_r[1] <= BOUND_HI_RST;
      bound_r[2] <= BOUND_LO_RST;
      bound_r[3] <= BOUND_HI_RST;
      bound_r[4] <= BOUND_LO_RST;
      bound_r[5] <= BOUND_HI_RST;
      scale_r    <= SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_BOUND_LEFT:  bound_r[0] <= cfg_wdata;
        CFG_BOUND_RIGHT: bound_r[1] <= cfg_wdata;
        CFG_BOUND_DOWN:  bound_r[2] <= cfg_wdata;
        CFG_BOUND_UP:    bound_r[3] <= cfg_wdata;
        CFG_BOUND_BACK:  bound_r[4] <= cfg_wdata;
        CFG_BOUND_FRONT: bound_r[5] <= cfg_wdata;
        CFG_SPEED_SCALE: scale_r    <= cfg_wdata[24:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NUM_STAGES-2:0], in_valid};
    end
  end

  // payload is held in d1_r and d2_r while the step is computed
  always_ff @(posedge clk) begin
    if (en) begin
      d1_r <= din;
      d2_r <= d1_r;
    end
  end

  bir_step u_step (
    .clk         (clk),
    .en          (en),
    .time_step   (in_time_step),
    .speed_scale (scale_r),
    .step        (step)
  );

  for (genvar a = 0; a < 3; a++) begin : g_axis
    bir_axis u_axis (
      .clk      (clk),
      .en       (en),
      .din      (d2_r[a]),
      .step     (step),
      .bound_lo (bound_r[2*a]),
      .bound_hi (bound_r[2*a+1]),
      .new_pos  (npos[a]),
      .new_vel  (nvel[a])
    );
  end

  assign out_valid     = vld_r[NUM_STAGES-1];
  assign out_new_pos_x = npos[0];
  assign out_new_pos_y = npos[1];
  assign out_new_pos_z = npos[2];
  assign out_new_vel_x = nvel[0];
  assign out_new_vel_y = nvel[1];
  assign out_new_vel_z = nvel[2];

endmodule

// ===== design/bir_step.sv =====
// Time step scaling: step = (time_step * speed_scale) >> 16, capped at 2^32.
module bir_step (
  input  logic                      clk,
  input  logic                      en,
  input  logic [24:0]               time_step,
  input  logic [24:0]               speed_scale,
  output logic [bir_pkg::STEP_W-1:0] step
);
  import bir_pkg::*;

  logic [49:0]       prod_r;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic [33:0]       st;

  always_comb begin
    st = prod_r[49:16];
    if (st > {1'b0, STEP_MAX}) begin
      step_nxt = STEP_MAX;
    end else begin
      step_nxt = st[STEP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= time_step * speed_scale;
      step_r <= step_nxt;
    end
  end

  assign step = step_r;

endmodule

// ===== design/bir_axis.sv =====
// One axis: move, saturate, face test against bounds, clamp and reflect.
module bir_axis (
  input  logic                       clk,
  input  logic                       en,
  input  bir_pkg::axis_in_t          din,
  input  logic [bir_pkg::STEP_W-1:0] step,
  input  bir_pkg::q16_t              bound_lo,
  input  bir_pkg::q16_t              bound_hi,
  output bir_pkg::q16_t              new_pos,
  output bir_pkg::q16_t              new_vel
);
  import bir_pkg::*;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // stage A: move
  logic signed [64:0] mul;
  logic signed [48:0] move_nxt;
  logic signed [48:0] move_a_r;
  q16_t               pos_a_r, vel_a_r;
  logic [29:0]        half_a_r;

  // stage B: moved centre
  logic signed [49:0] psum;
  q16_t               p_nxt;
  q16_t               p_b_r, vel_b_r;
  logic signed [48:0] move_b_r;
  logic [29:0]        half_b_r;

  // stage C: faces and clamp targets
  logic signed [50:0] lf_nxt, hf_nxt, mneg, mpos;
  logic signed [32:0] clo_sum, chi_sum;
  q16_t               clo_nxt, chi_nxt;
  logic signed [50:0] lf_c_r, hf_c_r;
  q16_t               clo_c_r, chi_c_r, p_c_r, vel_c_r;

  // stage D: decide
  logic               lo_hit, hi_hit;
  q16_t               pos_nxt, vel_nxt;
  q16_t               pos_d_r, vel_d_r;

  function automatic logic signed [49:0] p_sx(input q16_t v);
    p_sx = 50'(v);
  endfunction

  always_comb begin
    mul = din.vel * $signed({1'b0, step[31:0]});
    if (step[32]) begin
      move_nxt = {din.vel[31], din.vel, 16'd0};
    end else begin
      move_nxt = mul[64:16];
    end
  end

  always_comb begin
    psum = 50'(p_sx(pos_a_r)) + 50'(move_a_r);
    if (psum > 50'(S32_MAX)) begin
      p_nxt = S32_MAX;
    end else if (psum < 50'(S32_MIN)) begin
      p_nxt = S32_MIN;
    end else begin
      p_nxt = psum[31:0];
    end
  end

  always_comb begin
    mneg    = move_b_r[48] ? 51'(move_b_r) : '0;
    mpos    = (!move_b_r[48] && move_b_r != '0) ? 51'(move_b_r) : '0;
    lf_nxt  = 51'(p_b_r) - $signed({21'd0, half_b_r}) + mneg;
    hf_nxt  = 51'(p_b_r) + $signed({21'd0, half_b_r}) + mpos;
    clo_sum = 33'(bound_lo) + $signed({3'd0, half_b_r});
    chi_sum = 33'(bound_hi) - $signed({3'd0, half_b_r});
    if (clo_sum > 33'(S32_MAX)) begin
      clo_nxt = S32_MAX;
    end else begin
      clo_nxt = clo_sum[31:0];
    end
    if (chi_sum < 33'(S32_MIN)) begin
      chi_nxt = S32_MIN;
    end else begin
      chi_nxt = chi_sum[31:0];
    end
  end

  always_comb begin
    lo_hit  = lf_c_r <= 51'(bound_lo);
    hi_hit  = hf_c_r >= 51'(bound_hi);
    pos_nxt = p_c_r;
    vel_nxt = vel_c_r;
    if (lo_hit) begin
      pos_nxt = clo_c_r;
      if (vel_c_r[31]) begin
        vel_nxt = (vel_c_r == S32_MIN) ? S32_MAX : -vel_c_r;
      end
    end else if (hi_hit) begin
      pos_nxt = chi_c_r;
      if (!vel_c_r[31] && vel_c_r != '0) begin
        vel_nxt = -vel_c_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      move_a_r <= move_nxt;
      pos_a_r  <= din.pos;
      vel_a_r  <= din.vel;
      half_a_r <= din.size[30:1];

      p_b_r    <= p_nxt;
      vel_b_r  <= vel_a_r;
      move_b_r <= move_a_r;
      half_b_r <= half_a_r;

      lf_c_r   <= lf_nxt;
      hf_c_r   <= hf_nxt;
      clo_c_r  <= clo_nxt;
      chi_c_r  <= chi_nxt;
      p_c_r    <= p_b_r;
      vel_c_r  <= vel_b_r;

      pos_d_r  <= pos_nxt;
      vel_d_r  <= vel_nxt;
    end
  end

  assign new_pos = pos_d_r;
  assign new_vel = vel_d_r;

endmodule

// ===== dv/box_integrate_and_reflect_tb.sv =====
`timescale 1ns / 1ps
// Testbench for box_integrate_and_reflect: cuboid updates checked against an in-bench predictor.
module box_integrate_and_reflect_tb;
  import bir_pkg::*;

  typedef struct {
    q16_t        pos[3];
    q16_t        vel[3];
    logic [30:0] size[3];
    logic [24:0] ts;
  } box_item_t;

  typedef struct {
    q16_t pos[3];
    q16_t vel[3];
  } box_update_t;

  localparam q16_t        ONE            = 32'sh0001_0000;
  localparam q16_t        Q_MAX          = 32'sh7FFF_FFFF;
  localparam q16_t        Q_MIN          = 32'sh8000_0000;
  localparam logic [30:0] SIZE_MAX       = 31'h7FFF_FFFF;
  localparam logic [24:0] TS_MAX         = 25'h100_0000;
  localparam logic [24:0] TS_FULL        = 25'h1FF_FFFF;
  localparam logic [2:0]  CFG_NO_REG     = 3'd7;
  localparam int          WATCHDOG_LIMIT = 2000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  q16_t        in_pos_x  = '0;
  q16_t        in_pos_y  = '0;
  q16_t        in_pos_z  = '0;
  q16_t        in_vel_x  = '0;
  q16_t        in_vel_y  = '0;
  q16_t        in_vel_z  = '0;
  logic [30:0] in_size_x = '0;
  logic [30:0] in_size_y = '0;
  logic [30:0] in_size_z = '0;
  logic [24:0] in_time_step = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  q16_t        out_new_pos_x;
  q16_t        out_new_pos_y;
  q16_t        out_new_pos_z;
  q16_t        out_new_vel_x;
  q16_t        out_new_vel_y;
  q16_t        out_new_vel_z;
  logic        cfg_we    = 1'b0;
  cfg_idx_t    cfg_addr  = CFG_BOUND_LEFT;
  logic [31:0] cfg_wdata = '0;

  q16_t        encl_lo[3]  = '{BOUND_LO_RST, BOUND_LO_RST, BOUND_LO_RST};
  q16_t        encl_hi[3]  = '{BOUND_HI_RST, BOUND_HI_RST, BOUND_HI_RST};
  logic [24:0] speed_scale = SCALE_RST;

  box_update_t expected_updates[$];
  string       axis_tag[3] = '{"x", "y", "z"};
  int          mismatch_count = 0;
  int          items_sent     = 0;
  int          quiet_cycles   = 0;
  int          send_gap_pct   = 34;
  int          recv_stall_pct = 47;

  box_integrate_and_reflect dut (.*);

  always #2 clk = ~clk;

  function automatic q16_t clip32(longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return q16_t'(v);
  endfunction

  function automatic box_update_t integrate_and_reflect(box_item_t it);
    box_update_t r;
    longint      raw;
    longint      step;
    longint      mv;
    longint      p;
    longint      half;
    longint      lf;
    longint      hf;
    raw  = (longint'(it.ts) * longint'(speed_scale)) >> 16;
    step = (raw > longint'(STEP_MAX)) ? longint'(STEP_MAX) : raw;
    for (int a = 0; a < 3; a++) begin
      mv   = (longint'(it.vel[a]) * step) >>> 16;
      p    = longint'(clip32(longint'(it.pos[a]) + mv));
      half = longint'(it.size[a] >> 1);
      lf   = p - half + ((mv < 0) ? mv : 0);
      hf   = p + half + ((mv > 0) ? mv : 0);
      r.vel[a] = it.vel[a];
      if (lf <= longint'(encl_lo[a])) begin
        if (it.vel[a] < 0) r.vel[a] = clip32(-longint'(it.vel[a]));
        p = longint'(encl_lo[a]) + half;
      end else if (hf >= longint'(encl_hi[a])) begin
        if (it.vel[a] > 0) r.vel[a] = -it.vel[a];
        p = longint'(encl_hi[a]) - half;
      end
      r.pos[a] = clip32(p);
    end
    return r;
  endfunction

  function automatic box_item_t mk_item(q16_t px, py, pz, vx, vy, vz,
                                        logic [30:0] sx, sy, sz, logic [24:0] ts);
    box_item_t it;
    it.pos  = '{px, py, pz};
    it.vel  = '{vx, vy, vz};
    it.size = '{sx, sy, sz};
    it.ts   = ts;
    return it;
  endfunction

  function automatic longint signed_rand(int bits);
    return longint'($urandom_range(0, (32'd1 << bits) - 1)) - (longint'(1) << (bits - 1));
  endfunction

  // mostly boxes near a wall with moderate motion, plus noise, extremes and boxes near the centre
  function automatic box_item_t random_item();
    box_item_t it;
    longint    anchor;
    int        style;
    for (int a = 0; a < 3; a++) begin
      style = $urandom_range(0, 9);
      if (style < 6) begin
        anchor     = $urandom_range(0, 1) ? longint'(encl_lo[a]) : longint'(encl_hi[a]);
        it.pos[a]  = clip32(anchor + signed_rand(24));
        it.vel[a]  = q16_t'(signed_rand(20));
        it.size[a] = 31'($urandom_range(0, 32'h3F_FFFF));
      end else if (style < 8) begin
        it.pos[a]  = $urandom();
        it.vel[a]  = $urandom();
        it.size[a] = 31'($urandom());
      end else if (style == 8) begin
        case ($urandom_range(0, 2))
          0: it.pos[a] = Q_MIN;
          1: it.pos[a] = Q_MAX;
          default: it.pos[a] = '0;
        endcase
        case ($urandom_range(0, 3))
          0: it.vel[a] = Q_MIN;
          1: it.vel[a] = Q_MAX;
          2: it.vel[a] = -1;
          default: it.vel[a] = '0;
        endcase
        it.size[a] = $urandom_range(0, 1) ? SIZE_MAX : '0;
      end else begin
        anchor     = (longint'(encl_lo[a]) + longint'(encl_hi[a])) >>> 1;
        it.pos[a]  = clip32(anchor + signed_rand(16));
        it.vel[a]  = q16_t'(signed_rand(16));
        it.size[a] = 31'($urandom_range(0, 32'hFFFF));
      end
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: it.ts = 25'($urandom_range(0, 32'h4_0000));
      5, 6, 7:       it.ts = 25'($urandom_range(0, TS_MAX));
      8:             it.ts = TS_MAX;
      default:       it.ts = 25'($urandom());
    endcase
    return it;
  endfunction

  task automatic send_item(box_item_t it);
    if (items_sent < 172) begin
      send_gap_pct   = 34;
      recv_stall_pct = 47;
    end else if (items_sent < 344) begin
      send_gap_pct   = 47;
      recv_stall_pct = 34;
    end else begin
      send_gap_pct   = 0;
      recv_stall_pct = 0;
    end
    in_valid     <= 1'b1;
    in_pos_x     <= it.pos[0];
    in_pos_y     <= it.pos[1];
    in_pos_z     <= it.pos[2];
    in_vel_x     <= it.vel[0];
    in_vel_y     <= it.vel[1];
    in_vel_z     <= it.vel[2];
    in_size_x    <= it.size[0];
    in_size_y    <= it.size[1];
    in_size_z    <= it.size[2];
    in_time_step <= it.ts;
    do @(posedge clk); while (in_stall);
    items_sent++;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_updates();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_updates.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
    logic [2:0] code;
    code = idx;
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_SPEED_SCALE) speed_scale = data[24:0];
    else if (idx < CFG_SPEED_SCALE) begin
      if (code[0]) encl_hi[code[2:1]] = data;
      else encl_lo[code[2:1]] = data;
    end
  endtask

  task automatic set_enclosure(q16_t lo_x, hi_x, lo_y, hi_y, lo_z, hi_z,
                               logic [24:0] scale);
    write_reg(CFG_BOUND_LEFT, lo_x);
    write_reg(CFG_BOUND_RIGHT, hi_x);
    write_reg(CFG_BOUND_DOWN, lo_y);
    write_reg(CFG_BOUND_UP, hi_y);
    write_reg(CFG_BOUND_BACK, lo_z);
    write_reg(CFG_BOUND_FRONT, hi_z);
    write_reg(CFG_SPEED_SCALE, {7'd0, scale});
  endtask

  task automatic run_random(int count);
    repeat (count) send_item(random_item());
  endtask

  // reset enclosure of +/-100.0, unit speed scale
  task automatic test_directed_cases();
    send_item(mk_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(10 * ONE, -20 * ONE, 30 * ONE, ONE, -ONE, ONE / 2,
                      4 * ONE, 4 * ONE, 4 * ONE, ONE));
    send_item(mk_item(-99 * ONE, 99 * ONE, 0, -2 * ONE, 2 * ONE, 0,
                      2 * ONE, 2 * ONE, 2 * ONE, ONE));
    send_item(mk_item(-101 * ONE, 101 * ONE, 99 * ONE, ONE, -ONE, 0,
                      2 * ONE, 2 * ONE, 2 * ONE, ONE));
    send_item(mk_item(-99 * ONE, -99 * ONE + 1, 99 * ONE - 1, 0, 0, 0,
                      2 * ONE, 2 * ONE, 2 * ONE, 0));
    send_item(mk_item(0, 0, 0, Q_MIN, Q_MAX, Q_MIN, 0, 0, 0, ONE));
    send_item(mk_item(Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MIN, 0, 0, 0, TS_MAX));
    send_item(mk_item(0, 0, 0, ONE, -ONE, 0, SIZE_MAX, SIZE_MAX, SIZE_MAX, ONE));
    send_item(mk_item(0, 0, 0, -1, 1, -1, 0, 0, 0, 25'd1));
    send_item(mk_item(50 * ONE, -50 * ONE, 0, 3 * ONE, -3 * ONE, 7,
                      ONE, ONE, ONE, TS_MAX));
    // face widened by the move reaches the wall while the centre does not
    send_item(mk_item(90 * ONE, -90 * ONE, 0, ONE, -ONE, 0, 0, 0, 0, 5 * ONE));
    send_item(mk_item(Q_MIN, Q_MAX, 0, 0, 0, 0, SIZE_MAX, SIZE_MAX, 0, 0));
    drain_updates();
  endtask

  task automatic test_ignored_index();
    write_reg(cfg_idx_t'(CFG_NO_REG), 32'h0000_0000);
    send_item(mk_item(-99 * ONE, 99 * ONE, 0, -2 * ONE, 2 * ONE, 0,
                      2 * ONE, 2 * ONE, 2 * ONE, ONE));
    send_item(mk_item(ONE, -ONE, 0, 0, 0, 0, 4 * ONE, 4 * ONE, 0, ONE));
    send_item(mk_item(90 * ONE, -90 * ONE, 0, ONE, -ONE, 0, 0, 0, 0, 5 * ONE));
    drain_updates();
  endtask

  task automatic test_wide_enclosure();
    set_enclosure(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, TS_MAX);
    run_random(80);
    drain_updates();
  endtask

  task automatic test_inverted_enclosure();
    set_enclosure(Q_MAX, Q_MIN, 0, 0, ONE, -ONE, 25'd0);
    run_random(60);
    drain_updates();
  endtask

  task automatic test_random_enclosures();
    q16_t        lo[3];
    q16_t        hi[3];
    longint      mid;
    longint      reach;
    logic [24:0] scale;
    for (int k = 0; k < 6; k++) begin
      scale = 25'($urandom_range(0, TS_MAX));
      for (int a = 0; a < 3; a++) begin
        mid   = signed_rand(24) <<< 4;
        reach = longint'($urandom_range(ONE, 32'h400_0000));
        lo[a] = clip32(mid - reach);
        hi[a] = clip32(mid + reach);
        if (k == 1) begin
          lo[a] = Q_MIN;
          hi[a] = clip32(longint'(Q_MIN) + longint'($urandom_range(0, 32'hFFFF)));
        end else if (k == 5) begin
          lo[a] = $urandom();
          hi[a] = $urandom();
        end
      end
      if (k == 0) scale = TS_FULL;
      else if (k == 1) scale = ONE;
      set_enclosure(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2], scale);
      run_random(60);
      drain_updates();
    end
  endtask

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    box_item_t   seen;
    box_update_t want;
    q16_t        got_pos[3];
    q16_t        got_vel[3];
    got_pos = '{out_new_pos_x, out_new_pos_y, out_new_pos_z};
    got_vel = '{out_new_vel_x, out_new_vel_y, out_new_vel_z};
    if (rst_n && in_valid && !in_stall) begin
      seen.pos  = '{in_pos_x, in_pos_y, in_pos_z};
      seen.vel  = '{in_vel_x, in_vel_y, in_vel_z};
      seen.size = '{in_size_x, in_size_y, in_size_z};
      seen.ts   = in_time_step;
      expected_updates.push_back(integrate_and_reflect(seen));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_updates.size() == 0) begin
        $error("new_pos_x: expected no item, actual %0d", out_new_pos_x);
        mismatch_count++;
      end else begin
        want = expected_updates.pop_front();
        for (int a = 0; a < 3; a++) begin
          if (got_pos[a] !== want.pos[a]) begin
            $error("new_pos_%s: expected %0d, actual %0d", axis_tag[a], want.pos[a],
                   got_pos[a]);
            mismatch_count++;
          end
          if (got_vel[a] !== want.vel[a]) begin
            $error("new_vel_%s: expected %0d, actual %0d", axis_tag[a], want.vel[a],
                   got_vel[a]);
            mismatch_count++;
          end
        end
      end
    end
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_ignored_index();
    test_wide_enclosure();
    test_inverted_enclosure();
    test_random_enclosures();
    repeat (NUM_STAGES + 2) @(posedge clk);
    if (mismatch_count == 0 && expected_updates.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/bir_pkg.sv
design/bir_step.sv
design/bir_axis.sv
design/box_integrate_and_reflect.sv
dv/box_integrate_and_reflect_tb.sv
